[sv/itk_pkg.sv]
package itk_pkg;

  localparam int CFG_W   = 31;
  localparam int IDX_W   = 3;
  localparam int OFS_W   = 24;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 25;
  localparam int XY_W    = 34;
  localparam int SQ_IN_W = 60;
  localparam int SQ_OUT_W = 30;
  localparam int NUM_W   = 56;
  localparam int DEN_W   = 33;
  localparam int COV_FRAC = 24;
  localparam int CORDIC_STEPS = 20;

  localparam logic [IDX_W-1:0] REG_ANGLE_NOISE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROLL_BIAS_NOISE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PITCH_BIAS_NOISE = 3'd2;
  localparam logic [IDX_W-1:0] REG_MEASURE_NOISE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_STEP_TIME        = 3'd4;
  localparam logic [IDX_W-1:0] REG_GYRO_X_OFFSET    = 3'd5;
  localparam logic [IDX_W-1:0] REG_GYRO_Y_OFFSET    = 3'd6;

  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST      = 31'd16777;
  localparam logic [CFG_W-1:0] ROLL_BIAS_NOISE_RST  = 31'd50332;
  localparam logic [CFG_W-1:0] PITCH_BIAS_NOISE_RST = 31'd16777;
  localparam logic [CFG_W-1:0] MEASURE_NOISE_RST    = 31'd503316;
  localparam logic [CFG_W-1:0] STEP_TIME_RST        = 31'd41943;

  localparam logic signed [31:0] DEG180 = 32'sd11796480;
  localparam logic signed [31:0] DEG90  = 32'sd5898240;
  localparam logic signed [63:0] MUL_ROUND = 64'sd8388608;
  // (|raw| * 10240 + 20) / 41 as a multiply by ceil(2^35 / 41) and a shift
  localparam logic signed [31:0] GYRO_ROUND = 32'sd20;
  localparam logic signed [31:0] GYRO_RECIP = 32'sd838042400;
  localparam int GYRO_SHIFT = 35;

  typedef struct packed {
    logic busy;
    logic done;
  } itk_unit_st_t;

  typedef enum logic [5:0] {
    S_IDLE, S_SQRT, S_SQRT_WAIT, S_CORR_GO, S_CORR_WAIT, S_CORP_GO, S_CORP_WAIT,
    S_GX_GO, S_GX_WAIT, S_GY_GO, S_GY_WAIT, S_PITCH, S_ROLL,
    K_RATE, K_M_EST, K_A_EST, K_M_DP11, K_A_DP11, K_SUMT, K_M_P0, K_A_P0,
    K_M_P3, K_A_P3, K_S, K_D0_GO, K_D0_WAIT, K_D1_GO, K_D1_WAIT, K_Y,
    K_M_E2, K_A_E2, K_M_D2, K_A_D2, K_M_Q3, K_A_Q3, K_M_Q2, K_A_Q2,
    K_M_Q1, K_A_Q1, K_M_Q0, K_A_Q0, S_STORE, S_OUT
  } itk_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] mulr(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + MUL_ROUND) >>> COV_FRAC;
    return sat32(t);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input logic signed [31:0] v);
    logic signed [31:0] c;
    if (v > DEG180) c = DEG180;
    else if (v < -DEG180) c = -DEG180;
    else c = v;
    return c[OUT_W-1:0];
  endfunction

  function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0: r = 32'sd2949120;
      5'd1: r = 32'sd1740967;
      5'd2: r = 32'sd919879;
      5'd3: r = 32'sd466945;
      5'd4: r = 32'sd234379;
      5'd5: r = 32'sd117304;
      5'd6: r = 32'sd58666;
      5'd7: r = 32'sd29335;
      5'd8: r = 32'sd14668;
      5'd9: r = 32'sd7334;
      5'd10: r = 32'sd3667;
      5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;
      5'd13: r = 32'sd458;
      5'd14: r = 32'sd229;
      5'd15: r = 32'sd115;
      5'd16: r = 32'sd57;
      5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;
      5'd19: r = 32'sd7;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

[sv/itk_sqrt.sv]
module itk_sqrt import itk_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SQ_IN_W-1:0]  rad_in,
  output logic [SQ_OUT_W-1:0] root,
  output itk_unit_st_t        st
);
  logic [SQ_IN_W-1:0] rad;
  logic [33:0] rem, rem_sh, trial;
  logic [4:0] cnt;
  logic busy, done;

  assign rem_sh = {rem[31:0], rad[SQ_IN_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign st = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad <= rad_in;
        rem <= '0;
        root <= '0;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rad <= {rad[SQ_IN_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          root <= {root[SQ_OUT_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          root <= {root[SQ_OUT_W-2:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(SQ_OUT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[sv/itk_cordic.sv]
module itk_cordic import itk_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  output logic signed [31:0]     z,
  output itk_unit_st_t           st
);
  logic signed [XY_W-1:0] x, y, dx, dy;
  logic [4:0] step;
  logic busy, done;

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign st = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        if (y_in == '0) begin
          z <= x_in[XY_W-1] ? DEG180 : 32'sd0;
          done <= 1'b1;
        end else if (x_in[XY_W-1]) begin
          z <= y_in[XY_W-1] ? -DEG180 : DEG180;
          x <= -x_in;
          y <= -y_in;
          busy <= 1'b1;
        end else begin
          z <= 32'sd0;
          x <= x_in;
          y <= y_in;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (!y[XY_W-1]) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_q16(step);
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_q16(step);
        end
        step <= step + 5'd1;
        if (step == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[sv/itk_div.sv]
module itk_div import itk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output itk_unit_st_t     st
);
  logic [DEN_W-1:0] dv;
  logic [DEN_W:0] rem, rem_sh, diff;
  logic [5:0] cnt;
  logic busy, done, ge;

  assign rem_sh = {rem[DEN_W-1:0], quo[NUM_W-1]};
  assign ge = rem_sh >= {1'b0, dv};
  assign diff = rem_sh - {1'b0, dv};
  assign st = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= num;
        dv <= den;
        rem <= '0;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[NUM_W-2:0], ge};
        rem <= ge ? diff : rem_sh;
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[sv/imu_tilt_kalman_estimator_core.sv]
// A zero root, a non-positive innovation variance or a pitch seam crossing skips part of the
// work. A new sample is taken once the result of the last one is in the output register. The
// 56-step shared divider dominates (four gains), ahead of the root and each CORDIC pass.
// Reset (rst, synchronous): filter state cleared, registers to their defaults, no beat pending.
module imu_tilt_kalman_estimator_core import itk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  accel_x,
  input  logic signed [IN_W-1:0]  accel_y,
  input  logic signed [IN_W-1:0]  accel_z,
  input  logic signed [IN_W-1:0]  gyro_x,
  input  logic signed [IN_W-1:0]  gyro_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] roll_angle,
  output logic signed [OUT_W-1:0] pitch_angle,
  input  logic                    cfg_wr_en,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);
  itk_state_t state, state_next;

  logic [CFG_W-1:0] angle_noise, roll_bias_noise, pitch_bias_noise, measure_noise, step_time;
  logic signed [OFS_W-1:0] gyro_x_offset, gyro_y_offset;

  logic signed [31:0] roll_est, roll_drift, pitch_est, pitch_drift, last_pitch_out;
  logic signed [31:0] roll_cov [4];
  logic signed [31:0] pitch_cov [4];

  logic signed [IN_W-1:0] ax, ay, az, gx, gy;
  logic [31:0] sq;
  logic signed [31:0] roll_acc, pitch_acc, rate_x, rate_y;

  logic axis_roll;
  logic signed [31:0] k_est, k_drift, k_p0, k_p1, k_p2, k_p3;
  logic signed [31:0] k_rate, k_meas, k_qbias, k_r, k_dp11, k_k0, k_k1;
  logic signed [33:0] k_s;

  logic signed [31:0] mul_a, mul_b, mr;
  logic signed [63:0] prod;

  logic sqrt_start, cordic_start, div_start;
  logic [SQ_OUT_W-1:0] root;
  logic signed [XY_W-1:0] cordic_x, cordic_y;
  logic signed [31:0] cordic_z;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  itk_unit_st_t sqrt_st, cordic_st, div_st;

  logic signed [IN_W-1:0] g_raw;
  logic [IN_W-1:0] g_abs;
  logic [18:0] g5;
  logic signed [31:0] g_q;
  logic signed [63:0] quo_s;
  logic s_pos, wrap, out_load;

  logic signed [31:0] dt, an;

  assign dt = $signed({1'b0, step_time});
  assign an = $signed({1'b0, angle_noise});
  assign mr = mulr(prod);
  assign in_stall = (state != S_IDLE);
  assign s_pos = !k_s[33] && (k_s != '0);
  assign wrap = (pitch_acc < -DEG90 && last_pitch_out > DEG90) ||
                (pitch_acc > DEG90 && last_pitch_out < -DEG90);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  assign g_raw = (state == S_GX_GO) ? gx : gy;
  assign g_abs = g_raw[IN_W-1] ? IN_W'(-g_raw) : IN_W'(g_raw);
  assign g5 = 19'(g_abs) * 19'd5;
  assign g_q = $signed(32'(prod[63:GYRO_SHIFT]));
  assign quo_s = $signed({8'b0, div_quo});

  itk_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .rad_in({sq, 28'b0}),
    .root(root), .st(sqrt_st)
  );

  itk_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start), .x_in(cordic_x), .y_in(cordic_y),
    .z(cordic_z), .st(cordic_st)
  );

  itk_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_quo), .st(div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    sqrt_start = 1'b0;
    cordic_start = 1'b0;
    div_start = 1'b0;
    cordic_x = '0;
    cordic_y = '0;
    div_num = '0;
    div_den = '0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_IDLE: if (in_valid) state_next = S_SQRT;
      S_SQRT: begin
        if (sq == '0) state_next = S_CORP_GO;
        else begin
          sqrt_start = 1'b1;
          state_next = S_SQRT_WAIT;
        end
      end
      S_SQRT_WAIT: if (sqrt_st.done) state_next = S_CORR_GO;
      S_CORR_GO: begin
        cordic_start = 1'b1;
        cordic_x = XY_W'(root);
        cordic_y = XY_W'(ay) <<< 14;
        state_next = S_CORR_WAIT;
      end
      S_CORR_WAIT: if (cordic_st.done) state_next = S_CORP_GO;
      S_CORP_GO: begin
        cordic_start = 1'b1;
        cordic_x = XY_W'(az) <<< 14;
        cordic_y = -(XY_W'(ax) <<< 14);
        state_next = S_CORP_WAIT;
      end
      S_CORP_WAIT: if (cordic_st.done) state_next = S_GX_GO;
      S_GX_GO, S_GY_GO: begin
        mul_a = $signed({2'b00, g5, 11'b0}) + GYRO_ROUND;
        mul_b = GYRO_RECIP;
        state_next = (state == S_GX_GO) ? S_GX_WAIT : S_GY_WAIT;
      end
      S_GX_WAIT: state_next = S_GY_GO;
      S_GY_WAIT: state_next = S_PITCH;
      S_PITCH: state_next = wrap ? S_ROLL : K_RATE;
      S_ROLL: state_next = K_RATE;
      K_RATE: state_next = K_M_EST;
      K_M_EST: begin
        mul_a = dt;
        mul_b = k_r;
        state_next = K_A_EST;
      end
      K_A_EST: state_next = K_M_DP11;
      K_M_DP11: begin
        mul_a = dt;
        mul_b = k_p3;
        state_next = K_A_DP11;
      end
      K_A_DP11: state_next = K_SUMT;
      K_SUMT: state_next = K_M_P0;
      K_M_P0: begin
        mul_a = dt;
        mul_b = k_r;
        state_next = K_A_P0;
      end
      K_A_P0: state_next = K_M_P3;
      K_M_P3: begin
        mul_a = k_qbias;
        mul_b = dt;
        state_next = K_A_P3;
      end
      K_A_P3: state_next = K_S;
      K_S: state_next = K_D0_GO;
      K_D0_GO: begin
        if (s_pos) begin
          div_start = 1'b1;
          div_num = NUM_W'({abs32(k_p0), 24'b0});
          div_den = k_s[DEN_W-1:0];
          state_next = K_D0_WAIT;
        end else state_next = K_Y;
      end
      K_D0_WAIT: if (div_st.done) state_next = K_D1_GO;
      K_D1_GO: begin
        div_start = 1'b1;
        div_num = NUM_W'({abs32(k_p2), 24'b0});
        div_den = k_s[DEN_W-1:0];
        state_next = K_D1_WAIT;
      end
      K_D1_WAIT: if (div_st.done) state_next = K_Y;
      K_Y: state_next = K_M_E2;
      K_M_E2: begin
        mul_a = k_k0;
        mul_b = k_r;
        state_next = K_A_E2;
      end
      K_A_E2: state_next = K_M_D2;
      K_M_D2: begin
        mul_a = k_k1;
        mul_b = k_r;
        state_next = K_A_D2;
      end
      K_A_D2: state_next = K_M_Q3;
      K_M_Q3: begin
        mul_a = k_k1;
        mul_b = k_p1;
        state_next = K_A_Q3;
      end
      K_A_Q3: state_next = K_M_Q2;
      K_M_Q2: begin
        mul_a = k_k1;
        mul_b = k_p0;
        state_next = K_A_Q2;
      end
      K_A_Q2: state_next = K_M_Q1;
      K_M_Q1: begin
        mul_a = k_k0;
        mul_b = k_p1;
        state_next = K_A_Q1;
      end
      K_A_Q1: state_next = K_M_Q0;
      K_M_Q0: begin
        mul_a = k_k0;
        mul_b = k_p0;
        state_next = K_A_Q0;
      end
      K_A_Q0: state_next = S_STORE;
      S_STORE: state_next = axis_roll ? S_OUT : S_ROLL;
      S_OUT: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= ANGLE_NOISE_RST;
      roll_bias_noise <= ROLL_BIAS_NOISE_RST;
      pitch_bias_noise <= PITCH_BIAS_NOISE_RST;
      measure_noise <= MEASURE_NOISE_RST;
      step_time <= STEP_TIME_RST;
      gyro_x_offset <= '0;
      gyro_y_offset <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ANGLE_NOISE: angle_noise <= cfg_data;
        REG_ROLL_BIAS_NOISE: roll_bias_noise <= cfg_data;
        REG_PITCH_BIAS_NOISE: pitch_bias_noise <= cfg_data;
        REG_MEASURE_NOISE: measure_noise <= cfg_data;
        REG_STEP_TIME: step_time <= cfg_data;
        REG_GYRO_X_OFFSET: gyro_x_offset <= $signed(cfg_data[OFS_W-1:0]);
        REG_GYRO_Y_OFFSET: gyro_y_offset <= $signed(cfg_data[OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      roll_angle <= $signed(clamp_out(roll_est));
      pitch_angle <= $signed(clamp_out(last_pitch_out));
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_est <= '0;
      roll_drift <= '0;
      pitch_est <= '0;
      pitch_drift <= '0;
      last_pitch_out <= '0;
      for (int i = 0; i < 4; i++) begin
        roll_cov[i] <= '0;
        pitch_cov[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          ax <= accel_x;
          ay <= accel_y;
          az <= accel_z;
          gx <= gyro_x;
          gy <= gyro_y;
          sq <= 32'(32'(accel_x) * 32'(accel_x)) + 32'(32'(accel_z) * 32'(accel_z));
          roll_acc <= '0;
        end
        S_CORR_WAIT: if (cordic_st.done) roll_acc <= cordic_z;
        S_CORP_WAIT: if (cordic_st.done) pitch_acc <= cordic_z;
        S_GX_WAIT: rate_x <= (gx[IN_W-1] ? -g_q : g_q) - 32'(gyro_x_offset);
        S_GY_WAIT: rate_y <= (gy[IN_W-1] ? -g_q : g_q) - 32'(gyro_y_offset);
        S_PITCH: begin
          if (wrap) begin
            pitch_est <= pitch_acc;
            last_pitch_out <= pitch_acc;
          end else begin
            axis_roll <= 1'b0;
            k_est <= pitch_est;
            k_drift <= pitch_drift;
            k_p0 <= pitch_cov[0];
            k_p1 <= pitch_cov[1];
            k_p2 <= pitch_cov[2];
            k_p3 <= pitch_cov[3];
            k_meas <= pitch_acc;
            k_rate <= rate_y;
            k_qbias <= $signed({1'b0, pitch_bias_noise});
          end
        end
        S_ROLL: begin
          axis_roll <= 1'b1;
          k_est <= roll_est;
          k_drift <= roll_drift;
          k_p0 <= roll_cov[0];
          k_p1 <= roll_cov[1];
          k_p2 <= roll_cov[2];
          k_p3 <= roll_cov[3];
          k_meas <= roll_acc;
          k_rate <= rate_x;
          k_qbias <= $signed({1'b0, roll_bias_noise});
        end
        K_RATE: k_r <= sat32(64'(k_rate) - 64'(k_drift));
        K_A_EST: k_est <= sat32(64'(k_est) + 64'(mr));
        K_A_DP11: k_dp11 <= mr;
        K_SUMT: k_r <= sat32(64'(k_dp11) - 64'(k_p1) - 64'(k_p2) + 64'(an));
        K_A_P0: begin
          k_p0 <= sat32(64'(k_p0) + 64'(mr));
          k_p1 <= sat32(64'(k_p1) - 64'(k_dp11));
          k_p2 <= sat32(64'(k_p2) - 64'(k_dp11));
        end
        K_A_P3: k_p3 <= sat32(64'(k_p3) + 64'(mr));
        K_S: begin
          k_s <= 34'(k_p0) + 34'($signed({1'b0, measure_noise}));
          k_k0 <= '0;
          k_k1 <= '0;
        end
        K_D0_WAIT: if (div_st.done) k_k0 <= sat32(k_p0[31] ? -quo_s : quo_s);
        K_D1_WAIT: if (div_st.done) k_k1 <= sat32(k_p2[31] ? -quo_s : quo_s);
        K_Y: k_r <= sat32(64'(k_meas) - 64'(k_est));
        K_A_E2: k_est <= sat32(64'(k_est) + 64'(mr));
        K_A_D2: k_drift <= sat32(64'(k_drift) + 64'(mr));
        K_A_Q3: k_p3 <= sat32(64'(k_p3) - 64'(mr));
        K_A_Q2: k_p2 <= sat32(64'(k_p2) - 64'(mr));
        K_A_Q1: k_p1 <= sat32(64'(k_p1) - 64'(mr));
        K_A_Q0: k_p0 <= sat32(64'(k_p0) - 64'(mr));
        S_STORE: begin
          if (axis_roll) begin
            roll_est <= k_est;
            roll_drift <= k_drift;
            roll_cov[0] <= k_p0;
            roll_cov[1] <= k_p1;
            roll_cov[2] <= k_p2;
            roll_cov[3] <= k_p3;
          end else begin
            pitch_est <= k_est;
            pitch_drift <= k_drift;
            last_pitch_out <= k_est;
            pitch_cov[0] <= k_p0;
            pitch_cov[1] <= k_p1;
            pitch_cov[2] <= k_p2;
            pitch_cov[3] <= k_p3;
          end
        end
        default: ;
      endcase
    end
  end

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy) else $error("divider restarted while busy");

  a_cordic_free: assert property (@(posedge clk) disable iff (rst)
    cordic_start |-> !cordic_st.busy) else $error("cordic restarted while busy");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("second sample taken while busy");

  a_beat_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT) else $error("result beat outside output step");

endmodule
